// File: design/wrms_pkg.sv
// Shared types and constants for the windowed RMS audio meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wrms_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam int SUM_W   = 46;
	localparam int FRAME_W = 16;
	localparam int RMS_W   = 20;
	localparam int SQ_W    = 31;
	localparam int QUO_W   = SUM_W + 8;
	localparam int ROOT_W  = QUO_W / 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TWO_CHANNELS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRAMES = 2'd2;

	localparam logic [FRAME_W-1:0] WINDOW_RESET = 16'd256;

	typedef struct packed {
		logic       start_stream;
		logic [7:0] data_byte;
	} sample_t;

	typedef struct packed {
		logic [RMS_W-1:0] rms_left;
		logic [RMS_W-1:0] rms_right;
		logic [RMS_W-1:0] peak_rms;
	} meter_t;

	typedef struct packed {
		logic               wide;
		logic               two;
		logic [FRAME_W-1:0] frames;
	} cfg_t;

	// per-sample control carried down the front pipeline
	typedef struct packed {
		logic               have_l;
		logic               have_r;
		logic               clr_sum;
		logic               win_end;
		logic               two;
		logic               clr_peak;
		logic [FRAME_W-1:0] frames;
	} smp_ctl_t;

	// one finished window waiting for the divide/sqrt back end
	typedef struct packed {
		logic [SUM_W-1:0]   lsum;
		logic [SUM_W-1:0]   rsum;
		logic [FRAME_W-1:0] frames;
		logic               two;
		logic               clr_peak;
	} win_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_SQRT,
		B_DONE
	} back_state_t;

endpackage

// File: design/wrms_fifo.sv
// Small request queue of finished windows between front and back end.
// Depends on wrms_pkg (win_t).
`timescale 1ns / 1ps

module wrms_fifo import wrms_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  win_t                       wdata,
	input  logic                       pop,
	output win_t                       rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	win_t          mem [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/wrms_front.sv
// Front end: byte framing, sample squaring and per-window square sums.
// Depends on wrms_pkg; pushes finished windows into wrms_fifo.
`timescale 1ns / 1ps

module wrms_front import wrms_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  sample_t                    sample,
	input  logic [$clog2(DEPTH+1)-1:0] q_count,
	output logic                       q_push,
	output win_t                       q_wdata
);
	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]         pos_q;
	logic [7:0]         hold_q;
	logic [FRAME_W-1:0] frames_q;
	logic               pend_pk_q;

	logic               valid_s1, valid_s2;
	logic [15:0]        mag_s1;
	smp_ctl_t           ctl_s1, ctl_s2;
	logic [SQ_W-1:0]    sq_s2;

	logic [SUM_W-1:0]   lsum_q, rsum_q;

	logic               acc;
	logic [1:0]         pos_e, last;
	logic [7:0]         hold_e;
	logic [FRAME_W-1:0] frames_e, win;
	logic [FRAME_W:0]   frames_p1;
	logic               frame_end, win_end, clr_pk;
	logic [15:0]        word, mag;
	smp_ctl_t           ctl;
	logic [CW+1:0]      busy;
	logic [31:0]        prod;
	logic [SUM_W-1:0]   lsum_n, rsum_n;

	assign busy = (CW+2)'(q_count) + (CW+2)'(valid_s1 & ctl_s1.win_end)
		+ (CW+2)'(valid_s2 & ctl_s2.win_end);
	assign sample_ready = (busy < (CW+2)'(DEPTH));
	assign acc = sample_valid & sample_ready;

	always_comb begin
		pos_e    = sample.start_stream ? 2'd0 : pos_q;
		hold_e   = sample.start_stream ? 8'd0 : hold_q;
		frames_e = sample.start_stream ? '0 : frames_q;
		clr_pk   = sample.start_stream | pend_pk_q;
		case ({cfg.wide, cfg.two})
			2'b11:   last = 2'd3;
			2'b00:   last = 2'd0;
			default: last = 2'd1;
		endcase
		frame_end = (pos_e >= last);
		win       = (cfg.frames == '0) ? FRAME_W'(1) : cfg.frames;
		frames_p1 = {1'b0, frames_e} + 1'b1;
		win_end   = frame_end && (frames_p1 >= {1'b0, win});
		word      = {sample.data_byte, hold_e};
		if (cfg.wide) begin
			mag = word[15] ? (16'd0 - word) : word;
		end else begin
			mag = {8'd0, sample.data_byte};
		end
		ctl.have_l   = cfg.wide ? (pos_e == 2'd1) : (pos_e == 2'd0);
		ctl.have_r   = cfg.two && (cfg.wide ? (pos_e == 2'd3) : (pos_e == 2'd1));
		ctl.clr_sum  = sample.start_stream;
		ctl.win_end  = win_end;
		ctl.two      = cfg.two;
		ctl.clr_peak = clr_pk;
		ctl.frames   = frames_p1[FRAME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hold_q    <= '0;
			frames_q  <= '0;
			pend_pk_q <= 1'b0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			if (acc) begin
				pos_q <= frame_end ? 2'd0 : pos_e + 2'd1;
				if (cfg.wide && (pos_e == 2'd0 || pos_e == 2'd2)) begin
					hold_q <= sample.data_byte;
				end else begin
					hold_q <= hold_e;
				end
				if (frame_end) begin
					frames_q <= win_end ? '0 : frames_p1[FRAME_W-1:0];
				end else begin
					frames_q <= frames_e;
				end
				pend_pk_q <= clr_pk & ~win_end;
			end
		end
	end

	assign prod = mag_s1 * mag_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			mag_s1 <= mag;
			ctl_s1 <= ctl;
		end
		if (valid_s1) begin
			sq_s2  <= prod[SQ_W-1:0];
			ctl_s2 <= ctl_s1;
		end
	end

	always_comb begin
		lsum_n = (ctl_s2.clr_sum ? '0 : lsum_q)
			+ (ctl_s2.have_l ? SUM_W'(sq_s2) : '0);
		rsum_n = (ctl_s2.clr_sum ? '0 : rsum_q)
			+ (ctl_s2.have_r ? SUM_W'(sq_s2) : '0);
		q_push           = valid_s2 & ctl_s2.win_end;
		q_wdata.lsum     = lsum_n;
		q_wdata.rsum     = rsum_n;
		q_wdata.frames   = ctl_s2.frames;
		q_wdata.two      = ctl_s2.two;
		q_wdata.clr_peak = ctl_s2.clr_peak;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
			rsum_q <= '0;
		end else if (valid_s2) begin
			lsum_q <= ctl_s2.win_end ? '0 : lsum_n;
			rsum_q <= ctl_s2.win_end ? '0 : rsum_n;
		end
	end

endmodule

// File: design/wrms_back.sv
// Back end: per window, sum*256/frames by restoring division, integer
// square root, peak tracking and the output register. Depends on wrms_pkg.
`timescale 1ns / 1ps

module wrms_back import wrms_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_empty,
	input  win_t   q_rdata,
	output logic   q_pop,
	output logic   meter_valid,
	input  logic   meter_ready,
	output meter_t meter
);
	back_state_t        state_q, state_d;
	win_t               ent_q;
	logic               ch_q;
	logic [QUO_W-1:0]   dq_q;
	logic [FRAME_W:0]   drem_q;
	logic [ROOT_W+2:0]  srem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [5:0]         cnt_q;
	logic [RMS_W-1:0]   rl_q, rr_q, peak_q;
	logic               ov_q;
	meter_t             out_q;

	logic [FRAME_W:0]   r_div;
	logic               ge_div;
	logic [ROOT_W+2:0]  r_sq, trial;
	logic               ge_sq;
	logic [ROOT_W-1:0]  root_n;
	logic               div_last, sq_last, fire;
	logic [RMS_W-1:0]   pk;

	assign meter_valid = ov_q;
	assign meter       = out_q;

	always_comb begin
		r_div    = {drem_q[FRAME_W-1:0], dq_q[QUO_W-1]};
		ge_div   = (r_div >= {1'b0, ent_q.frames});
		r_sq     = {srem_q[ROOT_W:0], dq_q[QUO_W-1:QUO_W-2]};
		trial    = {1'b0, root_q, 2'b01};
		ge_sq    = (r_sq >= trial);
		root_n   = {root_q[ROOT_W-2:0], ge_sq};
		div_last = (cnt_q == 6'(QUO_W - 1));
		sq_last  = (cnt_q == 6'(ROOT_W - 1));
		fire     = !ov_q || meter_ready;
		pk       = ent_q.clr_peak ? '0 : peak_q;
		if (rl_q > pk) pk = rl_q;
		if (rr_q > pk) pk = rr_q;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (div_last) state_d = B_SQRT;
			end
			B_SQRT: begin
				if (sq_last) state_d = (!ch_q && ent_q.two) ? B_DIV : B_DONE;
			end
			B_DONE: begin
				if (fire) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			peak_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_DONE && fire) begin
				peak_q <= pk;
				ov_q   <= 1'b1;
			end else if (meter_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ent_q  <= q_rdata;
				ch_q   <= 1'b0;
				dq_q   <= {q_rdata.lsum, 8'd0};
				drem_q <= '0;
				cnt_q  <= '0;
			end
			B_DIV: begin
				drem_q <= ge_div ? r_div - {1'b0, ent_q.frames} : r_div;
				dq_q   <= {dq_q[QUO_W-2:0], ge_div};
				cnt_q  <= div_last ? '0 : cnt_q + 1'b1;
				srem_q <= '0;
				root_q <= '0;
			end
			B_SQRT: begin
				srem_q <= ge_sq ? r_sq - trial : r_sq;
				root_q <= root_n;
				cnt_q  <= sq_last ? '0 : cnt_q + 1'b1;
				if (sq_last && !ch_q) begin
					rl_q   <= root_n[RMS_W-1:0];
					rr_q   <= '0;
					ch_q   <= 1'b1;
					dq_q   <= {ent_q.rsum, 8'd0};
					drem_q <= '0;
				end else begin
					dq_q <= {dq_q[QUO_W-3:0], 2'b00};
					if (sq_last) begin
						rr_q <= root_n[RMS_W-1:0];
					end
				end
			end
			B_DONE: begin
				if (fire) begin
					out_q.rms_left  <= rl_q;
					out_q.rms_right <= rr_q;
					out_q.peak_rms  <= pk;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: design/windowed_rms_audio_meter_core.sv
// Windowed RMS audio meter, top level: configuration registers, front end,
// window queue and divide/sqrt back end. Depends on wrms_pkg and submodules.
`timescale 1ns / 1ps
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) takes one PCM byte per
//   request; start_stream clears framing, square sums and peak first.
//   meter channel (meter_valid/meter_ready/meter) gives one result per
//   complete window: left and right RMS in Q4 and the running peak.
//   cfg_we/cfg_idx/cfg_wdata write wide_samples, two_channels and
//   window_frames; write only while the block is idle.
// Timing:
//   bytes are taken one per cycle while sample_ready is high; the square sums
//   update through the s1 (magnitude) and s2 (square) registers, and a finished
//   window enters a QUEUE_DEPTH-entry queue as the sums update. The back end
//   takes a window in B_IDLE, runs 54 divide and 27 square-root steps per
//   channel on one shared sequential unit (left, then right when stereo) and
//   updates the peak in B_DONE. Input stalls only when the queue could fill.
// Reset clears all framing, sums, peak and queue; registers return to
//   16-bit stereo, 256 frames. A stalled receiver holds the result in the
//   output register; the back end computes the next window meanwhile.

module windowed_rms_audio_meter_core import wrms_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  meter_valid,
	input  logic                  meter_ready,
	output meter_t                meter
);
	cfg_t                       cfg_q;
	logic                       q_push, q_pop, q_empty;
	win_t                       q_wdata, q_rdata;
	logic [$clog2(DEPTH+1)-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide   <= 1'b1;
			cfg_q.two    <= 1'b1;
			cfg_q.frames <= WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WIDE_SAMPLES:  cfg_q.wide   <= cfg_wdata[0];
				CFG_TWO_CHANNELS:  cfg_q.two    <= cfg_wdata[0];
				CFG_WINDOW_FRAMES: cfg_q.frames <= cfg_wdata[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	wrms_front #(.DEPTH(DEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.q_count      (q_count),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	wrms_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	wrms_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.meter_valid (meter_valid),
		.meter_ready (meter_ready),
		.meter       (meter)
	);

endmodule

// File: bench/tb_windowed_rms_audio_meter_core.sv
// Self-checking bench for windowed_rms_audio_meter_core: a directed table, then random PCM
// byte streams under changing formats and windows, compared against a level predictor.
// Depends on wrms_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_windowed_rms_audio_meter_core;
	import wrms_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int SETTLE_CYC   = 40;
	localparam int N_DIR        = 25;
	localparam int RAND_PHASES  = 16;
	localparam int PHASE_ITEMS  = 100;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic               wide;
		logic               two;
		logic [FRAME_W-1:0] win;
		logic               st;
		logic [7:0]         b;
		logic               chk;
		logic [RMS_W-1:0]   el;
		logic [RMS_W-1:0]   er;
		logic [RMS_W-1:0]   ep;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample = '0;
	logic                  meter_valid;
	logic                  meter_ready = 1'b0;
	meter_t                meter;

	// predictor state and register copies
	logic               cur_wide;
	logic               cur_two;
	logic [FRAME_W-1:0] cur_win;
	logic [7:0]         hold_lo;
	logic [1:0]         byte_pos;
	logic [FRAME_W-1:0] frame_cnt;
	logic [SUM_W-1:0]   sum_l;
	logic [SUM_W-1:0]   sum_r;
	logic [RMS_W-1:0]   peak_lvl;

	meter_t levels_due[$];

	int cycle_cnt = 0;
	int err_cnt = 0;
	int req_cnt = 0;
	int res_cnt = 0;
	int cfg_cnt = 0;
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;

	dir_row_t dir_rows [0:N_DIR-1] = '{
		// 16-bit stereo, window 0 (acts as 1): full-scale negative and positive
		'{1, 1, 0, 1, 8'h00, 0, 0, 0, 0},
		'{1, 1, 0, 0, 8'h80, 0, 0, 0, 0},
		'{1, 1, 0, 0, 8'hFF, 0, 0, 0, 0},
		'{1, 1, 0, 0, 8'h7F, 1, 20'h80000, 20'h7FFF0, 20'h80000},
		'{1, 1, 0, 0, 8'h01, 0, 0, 0, 0},
		'{1, 1, 0, 0, 8'h00, 0, 0, 0, 0},
		'{1, 1, 0, 0, 8'hFF, 0, 0, 0, 0},
		'{1, 1, 0, 0, 8'hFF, 1, 20'd16, 20'd16, 20'h80000},
		// 8-bit stereo, window 1; start clears peak
		'{0, 1, 1, 1, 8'hFF, 0, 0, 0, 0},
		'{0, 1, 1, 0, 8'h00, 1, 20'd4080, 20'd0, 20'd4080},
		'{0, 1, 1, 0, 8'h00, 0, 0, 0, 0},
		'{0, 1, 1, 0, 8'hFF, 1, 20'd0, 20'd4080, 20'd4080},
		// 8-bit mono, window 2
		'{0, 0, 2, 1, 8'h80, 0, 0, 0, 0},
		'{0, 0, 2, 0, 8'h80, 1, 20'd2048, 20'd0, 20'd2048},
		'{0, 0, 2, 0, 8'h01, 0, 0, 0, 0},
		'{0, 0, 2, 0, 8'h02, 0, 0, 0, 0},
		// 16-bit mono, window 3, then start in mid-frame
		'{1, 0, 3, 1, 8'h34, 0, 0, 0, 0},
		'{1, 0, 3, 0, 8'h12, 0, 0, 0, 0},
		'{1, 0, 3, 0, 8'hCD, 0, 0, 0, 0},
		'{1, 0, 3, 0, 8'hAB, 0, 0, 0, 0},
		'{1, 0, 3, 0, 8'h00, 0, 0, 0, 0},
		'{1, 0, 3, 0, 8'h00, 0, 0, 0, 0},
		'{1, 0, 3, 0, 8'h11, 0, 0, 0, 0},
		'{1, 0, 3, 1, 8'h00, 0, 0, 0, 0},
		'{1, 0, 3, 0, 8'h80, 0, 0, 0, 0}
	};

	windowed_rms_audio_meter_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.meter_valid  (meter_valid),
		.meter_ready  (meter_ready),
		.meter        (meter)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int k = 31; k >= 0; k--) begin
			trial = root | (64'd1 << k);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [63:0] word_square(input logic [7:0] lo, input logic [7:0] hi);
		logic [15:0] w;
		logic [63:0] mag;
		w = {hi, lo};
		mag = w[15] ? (64'h10000 - {48'd0, w}) : {48'd0, w};
		return mag * mag;
	endfunction

	function automatic logic [RMS_W-1:0] window_rms(input logic [SUM_W-1:0] s,
			input logic [63:0] nfr);
		logic [63:0] q;
		logic [63:0] r;
		q = ({18'd0, s} << 8) / nfr;
		r = root_floor(q);
		return r[RMS_W-1:0];
	endfunction

	function automatic bit predict_levels(input logic st, input logic [7:0] b,
			output meter_t lv);
		logic [1:0]  at;
		logic [1:0]  last_pos;
		logic [63:0] sq_l;
		logic [63:0] sq_r;
		logic [63:0] nfr;
		logic [63:0] win;
		bit          add_l;
		bit          add_r;
		lv = '0;
		sq_l = '0;
		sq_r = '0;
		add_l = 0;
		add_r = 0;
		if (st) begin
			hold_lo = '0;
			byte_pos = '0;
			frame_cnt = '0;
			sum_l = '0;
			sum_r = '0;
			peak_lvl = '0;
		end
		at = byte_pos;
		if (cur_wide && cur_two)
			last_pos = 2'd3;
		else if (cur_wide || cur_two)
			last_pos = 2'd1;
		else
			last_pos = 2'd0;
		if (cur_wide) begin
			if (at == 2'd0 || at == 2'd2) begin
				hold_lo = b;
			end else if (at == 2'd1) begin
				sq_l = word_square(hold_lo, b);
				add_l = 1;
			end else if (cur_two) begin
				sq_r = word_square(hold_lo, b);
				add_r = 1;
			end
		end else begin
			if (at == 2'd0) begin
				sq_l = {56'd0, b} * {56'd0, b};
				add_l = 1;
			end else if (at == 2'd1 && cur_two) begin
				sq_r = {56'd0, b} * {56'd0, b};
				add_r = 1;
			end
		end
		if (add_l)
			sum_l = sum_l + sq_l[SUM_W-1:0];
		if (add_r)
			sum_r = sum_r + sq_r[SUM_W-1:0];
		if (at < last_pos) begin
			byte_pos = at + 2'd1;
			return 0;
		end
		byte_pos = '0;
		win = (cur_win == '0) ? 64'd1 : {48'd0, cur_win};
		nfr = {48'd0, frame_cnt} + 64'd1;
		if (nfr < win) begin
			frame_cnt = nfr[FRAME_W-1:0];
			return 0;
		end
		lv.rms_left = window_rms(sum_l, nfr);
		lv.rms_right = cur_two ? window_rms(sum_r, nfr) : '0;
		if (lv.rms_left > peak_lvl)
			peak_lvl = lv.rms_left;
		if (lv.rms_right > peak_lvl)
			peak_lvl = lv.rms_right;
		lv.peak_rms = peak_lvl;
		frame_cnt = '0;
		sum_l = '0;
		sum_r = '0;
		return 1;
	endfunction

	task automatic note_mismatch(input string what, input meter_t e, input meter_t a);
		err_cnt++;
		if (err_cnt <= REPORT_LIMIT)
			$display("%0t: %s: expected L=%0d R=%0d P=%0d, got L=%0d R=%0d P=%0d",
				$realtime, what, e.rms_left, e.rms_right, e.peak_rms,
				a.rms_left, a.rms_right, a.peak_rms);
	endtask

	// runs at the edge after the previous request; leaves valid high on return
	task automatic send_req(input logic st, input logic [7:0] b, input bit typed,
			input meter_t typed_lv);
		meter_t lv;
		bit     got;
		while (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{start_stream: st, data_byte: b};
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		req_cnt++;
		got = predict_levels(st, b, lv);
		if (typed)
			levels_due = {levels_due, typed_lv};
		else if (got)
			levels_due = {levels_due, lv};
	endtask

	task automatic await_idle();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (levels_due.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_cfg(input logic wide, input logic two, input logic [FRAME_W-1:0] win);
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			case (i)
				0: begin
					cfg_idx <= CFG_WIDE_SAMPLES;
					cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, wide};
				end
				1: begin
					cfg_idx <= CFG_TWO_CHANNELS;
					cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, two};
				end
				default: begin
					cfg_idx <= CFG_WINDOW_FRAMES;
					cfg_wdata <= win;
				end
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_wide = wide;
		cur_two = two;
		cur_win = win;
		cfg_cnt++;
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			1: begin
				tx_gap_pct = 49;
				rx_stall_pct = 0;
			end
			2: begin
				tx_gap_pct = 0;
				rx_stall_pct = 49;
			end
			3: begin
				tx_gap_pct = 7;
				rx_stall_pct = 7;
			end
			default: begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end
		endcase
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, levels_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			meter_ready <= 1'b0;
		else
			meter_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && meter_valid && meter_ready) begin
			res_cnt++;
			if (levels_due.size() == 0)
				note_mismatch("unexpected result", '0, meter);
			else if (meter.rms_left !== levels_due[0].rms_left ||
					meter.rms_right !== levels_due[0].rms_right ||
					meter.peak_rms !== levels_due[0].peak_rms)
				note_mismatch("level mismatch", levels_due[0], meter);
			if (levels_due.size() != 0)
				void'(levels_due.pop_front());
		end
	end

	initial begin
		dir_row_t  row;
		meter_t    typed_lv;
		logic      st;
		logic      wide;
		logic      two;
		logic [FRAME_W-1:0] win;
		int        pick;

		cur_wide = 1'b1;
		cur_two = 1'b1;
		cur_win = WINDOW_RESET;
		hold_lo = '0;
		byte_pos = '0;
		frame_cnt = '0;
		sum_l = '0;
		sum_r = '0;
		peak_lvl = '0;
		set_idle_mode(0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			row = dir_rows[i];
			if (i == 0 || row.wide != cur_wide || row.two != cur_two || row.win != cur_win) begin
				await_idle();
				write_cfg(row.wide, row.two, row.win);
			end
			typed_lv = '{rms_left: row.el, rms_right: row.er, peak_rms: row.ep};
			send_req(row.st, row.b, row.chk, typed_lv);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			await_idle();
			if (ph < 4) begin
				wide = ph[0];
				two = ph[1];
			end else begin
				wide = 1'($urandom);
				two = 1'($urandom);
			end
			pick = $urandom_range(0, 19);
			if (ph == 1 || (ph > 3 && pick == 0))
				win = 16'hFFFF;
			else if (ph == 2 || (ph > 3 && pick == 1))
				win = '0;
			else if (pick == 2)
				win = 16'($urandom_range(20, 64));
			else
				win = 16'($urandom_range(1, 6));
			write_cfg(wide, two, win);
			set_idle_mode(ph % 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				st = (k == 0 && $urandom_range(0, 2) == 0) || $urandom_range(0, 63) == 0;
				send_req(st, pick_byte(), 0, '0);
				if ((ph == 5 && k == 50) || $urandom_range(0, 199) == 0) begin
					// hold off until the meter side has caught up
					sample_valid <= 1'b0;
					do
						@(posedge clk);
					while (levels_due.size() != 0);
				end
			end
		end

		await_idle();
		if (levels_due.size() != 0) begin
			err_cnt += levels_due.size();
			$display("%0d expected results never arrived", levels_due.size());
		end
		$display("Sent %0d byte requests (%0d directed) under %0d register settings; %0d results.",
			req_cnt, N_DIR, cfg_cnt, res_cnt);
		$display("Covered 8/16-bit mono/stereo, windows 0 to 65535, starts and mid-frame changes.");
		if (err_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
